// ===== hw/rtl/tmg_pkg.sv =====
// Shared types, constants and arithmetic helpers of the torus mesh generator.
// No dependencies; all other files but tmg_channels import this package.
`timescale 1ns / 1ps
package tmg_pkg;

	localparam int MAX_SEGMENTS  = 256;
	localparam int FRACTION_BITS = 16;
	localparam int FULL_TURN     = 65536;
	localparam int ADDR_W        = 5;
	localparam int REG_COUNT     = 5;

	localparam logic FUNC_VERTEX = 1'b0;
	localparam logic FUNC_QUAD   = 1'b1;

	typedef enum logic [2:0] {
		REG_MAJOR,
		REG_MINOR,
		REG_RING,
		REG_TUBE,
		REG_SWEEP
	} reg_idx_t;

	localparam logic [3:0] VERTEX_WORDS = 4'd8;
	localparam logic [3:0] QUAD_WORDS   = 4'd6;
	localparam logic [3:0] FLAG_WORDS   = 4'd1;

	// divider: four lanes, each a long division of a 41 bit value by a 9 bit count
	localparam int LANES          = 4;
	localparam int LANE_A         = 0;	// sweep phase
	localparam int LANE_B         = 1;	// ring phase
	localparam int LANE_U         = 2;	// u texture coordinate
	localparam int LANE_V         = 3;	// v texture coordinate
	localparam int QUO_BITS       = 32;
	localparam int DIV_BITS_STAGE = 4;
	localparam int DIV_STAGES     = QUO_BITS / DIV_BITS_STAGE;

	localparam int CORDIC_STEPS    = 20;
	localparam int STEPS_PER_STAGE = 2;
	localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE + 1;
	localparam int CS_A            = 0;
	localparam int CS_B            = 1;
	localparam int MUL_STAGES      = 4;
	localparam int PIPE_DEPTH      = 1 + DIV_STAGES + CORDIC_STAGES + MUL_STAGES;

	localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;
	localparam logic signed [33:0] ATAN_TURNS [CORDIC_STEPS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
		34'sd21354465,  34'sd10679838,  34'sd5340245,   34'sd2670163,  34'sd1335087,
		34'sd667544,    34'sd333772,    34'sd166886,    34'sd83443,    34'sd41722,
		34'sd20861,     34'sd10430,     34'sd5215,      34'sd2608,     34'sd1304
	};

	localparam logic [30:0] RST_MAJOR = 31'd65536;
	localparam logic [30:0] RST_MINOR = 31'd16384;
	localparam logic [8:0]  RST_RING  = 9'd16;
	localparam logic [8:0]  RST_TUBE  = 9'd32;
	localparam logic [16:0] RST_SWEEP = 17'd65536;

	typedef struct packed {
		logic [30:0] major_radius;
		logic [30:0] minor_radius;
		logic [8:0]  ring_segments;
		logic [8:0]  tube_segments;
		logic [16:0] sweep_turns;
		logic        ok;
		logic        closed;
	} cfg_t;

	typedef struct packed {
		logic [8:0]  rem;
		logic [31:0] w;
	} div_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		logic [1:0]         quad;
	} cordic_t;

	typedef struct packed {
		logic [7:0][31:0] words;
		logic             func;
		logic             bad;
	} res_t;

	// restoring division: shift a numerator bit into the remainder, subtract when it fits
	function automatic div_t div_stage(input div_t din, input logic [8:0] dvs);
		div_t       r;
		logic [9:0] r2;
		r = din;
		for (int k = 0; k < DIV_BITS_STAGE; k++) begin
			r2 = {r.rem, r.w[31]};
			r.w = {r.w[30:0], 1'b0};
			if (r2 >= {1'b0, dvs}) begin
				r2 = r2 - {1'b0, dvs};
				r.w[0] = 1'b1;
			end
			r.rem = r2[8:0];
		end
		return r;
	endfunction

	function automatic cordic_t cordic_step(input cordic_t c, input int i);
		cordic_t            r;
		logic signed [33:0] xs;
		logic signed [33:0] ys;
		r = c;
		xs = c.x >>> i;
		ys = c.y >>> i;
		if (c.z >= 0) begin
			r.x = c.x - ys;
			r.y = c.y + xs;
			r.z = c.z - ATAN_TURNS[i];
		end else begin
			r.x = c.x + ys;
			r.y = c.y - xs;
			r.z = c.z + ATAN_TURNS[i];
		end
		return r;
	endfunction

	// round to nearest, ties up, then clamp to signed 32 bits
	function automatic logic signed [31:0] round_sat(input logic signed [67:0] v,
			input int sh);
		logic signed [67:0] t;
		t = (v + (68'sd1 <<< (sh - 1))) >>> sh;
		if (t > 68'sd2147483647)
			return 32'sh7fffffff;
		if (t < -68'sd2147483648)
			return 32'sh80000000;
		return t[31:0];
	endfunction

endpackage

// ===== hw/rtl/tmg_channels.sv =====
// Request and result channel interfaces of the torus mesh generator.
// No dependencies.
`timescale 1ns / 1ps
interface tmg_req_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [8:0] tube_index;
	logic [7:0] ring_index;

	modport source (output valid, func, tube_index, ring_index, input ready);
	modport sink (input valid, func, tube_index, ring_index, output ready);
endinterface

interface tmg_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] word;
	logic               last;
	logic               bad_index;

	modport source (output valid, word, last, bad_index, input ready);
	modport sink (input valid, word, last, bad_index, output ready);
endinterface

// ===== hw/rtl/tmg_cfg.sv =====
// APB register bank of the torus mesh generator and settings check.
// Depends on tmg_pkg.
`timescale 1ns / 1ps
module tmg_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [tmg_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output tmg_pkg::cfg_t             cfg
);
	import tmg_pkg::*;

	logic [30:0] major_q;
	logic [30:0] minor_q;
	logic [8:0]  ring_q;
	logic [8:0]  tube_q;
	logic [16:0] sweep_q;
	reg_idx_t    idx;
	logic        wr;

	assign pready = 1'b1;
	assign idx = reg_idx_t'(paddr[4:2]);
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_q <= RST_MAJOR;
			minor_q <= RST_MINOR;
			ring_q <= RST_RING;
			tube_q <= RST_TUBE;
			sweep_q <= RST_SWEEP;
		end else if (wr) begin
			unique case (idx)
				REG_MAJOR: major_q <= pwdata[30:0];
				REG_MINOR: minor_q <= pwdata[30:0];
				REG_RING:  ring_q <= pwdata[8:0];
				REG_TUBE:  tube_q <= pwdata[8:0];
				REG_SWEEP: sweep_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MAJOR: prdata = {1'b0, major_q};
			REG_MINOR: prdata = {1'b0, minor_q};
			REG_RING:  prdata = {23'h0, ring_q};
			REG_TUBE:  prdata = {23'h0, tube_q};
			REG_SWEEP: prdata = {15'h0, sweep_q};
			default:   prdata = 32'h0;
		endcase
	end

	always_comb begin
		cfg.major_radius = major_q;
		cfg.minor_radius = minor_q;
		cfg.ring_segments = ring_q;
		cfg.tube_segments = tube_q;
		cfg.sweep_turns = sweep_q;
		cfg.closed = sweep_q == 17'(FULL_TURN);
		cfg.ok = major_q != '0 && minor_q != '0 && ring_q >= 9'd3
			&& 32'(ring_q) <= MAX_SEGMENTS && tube_q >= 9'd3
			&& 32'(tube_q) <= MAX_SEGMENTS && sweep_q != '0
			&& 32'(sweep_q) <= FULL_TURN;
	end

endmodule

// ===== hw/rtl/tmg_divider.sv =====
// Pipelined four-lane divider for phases and texture coordinates.
// Depends on tmg_pkg.
`timescale 1ns / 1ps
module tmg_divider (
	input  logic          clk,
	input  logic          en,
	input  tmg_pkg::div_t din [tmg_pkg::LANES],
	input  logic [8:0]    dvs [tmg_pkg::LANES],
	output logic [31:0]   quo [tmg_pkg::LANES]
);
	import tmg_pkg::*;

	div_t st_s [DIV_STAGES][LANES];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				st_s[0][l] <= div_stage(din[l], dvs[l]);
				for (int s = 1; s < DIV_STAGES; s++)
					st_s[s][l] <= div_stage(st_s[s-1][l], dvs[l]);
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++)
			quo[l] = st_s[DIV_STAGES-1][l].w;
	end

endmodule

// ===== hw/rtl/tmg_cordic.sv =====
// Pipelined two-lane CORDIC giving Q30 cosine and sine of turn-based phases.
// Depends on tmg_pkg.
`timescale 1ns / 1ps
module tmg_cordic (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        phase [2],
	output logic signed [33:0] cos_val [2],
	output logic signed [33:0] sin_val [2]
);
	import tmg_pkg::*;

	cordic_t st_s [CORDIC_STAGES][2];
	cordic_t red [2];
	cordic_t fin;

	// fold the phase into the quadrant around zero
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			red[l].quad = 2'((phase[l] + 32'h2000_0000) >> 30);
			red[l].z = 34'($signed(phase[l] - {red[l].quad, 30'h0}));
			red[l].x = CORDIC_INV_GAIN;
			red[l].y = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				st_s[0][l] <= red[l];
				for (int s = 1; s < CORDIC_STAGES; s++)
					st_s[s][l] <= cordic_step(cordic_step(st_s[s-1][l],
						STEPS_PER_STAGE * s - 2), STEPS_PER_STAGE * s - 1);
			end
		end
	end

	// rotate back by the folded quadrant
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			fin = st_s[CORDIC_STAGES-1][l];
			case (fin.quad)
				2'd0: begin
					cos_val[l] = fin.x;
					sin_val[l] = fin.y;
				end
				2'd1: begin
					cos_val[l] = -fin.y;
					sin_val[l] = fin.x;
				end
				2'd2: begin
					cos_val[l] = -fin.x;
					sin_val[l] = -fin.y;
				end
				default: begin
					cos_val[l] = fin.y;
					sin_val[l] = -fin.x;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/tmg_serializer.sv =====
// Result serializer: holds one finished run and emits it word by word on rsp.
// Depends on tmg_pkg and tmg_channels.
`timescale 1ns / 1ps
module tmg_serializer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  tmg_pkg::res_t res,
	output logic          ser_ready,
	tmg_rsp_if.source     rsp
);
	import tmg_pkg::*;

	logic [7:0][31:0] sh_q;
	logic [3:0]       left_q;
	logic             bad_q;
	logic             take;

	assign take = rsp.valid && rsp.ready;
	assign ser_ready = left_q == '0 || (take && left_q == 4'd1);
	assign rsp.valid = left_q != '0;
	assign rsp.word = $signed(sh_q[0]);
	assign rsp.last = left_q == 4'd1;
	assign rsp.bad_index = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			bad_q <= 1'b0;
		end else if (load) begin
			bad_q <= res.bad;
			if (res.bad)
				left_q <= FLAG_WORDS;
			else if (res.func == FUNC_QUAD)
				left_q <= QUAD_WORDS;
			else
				left_q <= VERTEX_WORDS;
		end else if (take) begin
			left_q <= left_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			sh_q <= res.bad ? '0 : res.words;
		else if (take)
			sh_q <= sh_q >> 32;
	end

	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ser_ready)
		else $error("run loaded over a pending run");
	a_flag_single: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.bad_index) |-> (rsp.last && rsp.word == 32'sd0))
		else $error("flagged result is not a single zero word");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(take && rsp.last && !load) |=> !rsp.valid)
		else $error("result still valid after final word");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !rsp.last) |=> (rsp.valid && $past(left_q) == left_q + 4'd1))
		else $error("run did not advance by one word");

endmodule

// ===== hw/rtl/torus_mesh_generator.sv =====
// Top level of the torus mesh generator: request stage, multiply stages, glue.
// Depends on tmg_pkg, tmg_channels, tmg_cfg, tmg_divider, tmg_cordic, tmg_serializer.
//
// Usage: each request on req names a grid cell (tube_index, ring_index) and a func:
// vertex gives eight Q16.16 words x, y, z, nx, ny, nz, u, v; quad gives six vertex
// indices. A cell outside the grid, or any request under bad settings, gives one
// zero word with bad_index and last set. last marks the final word of every run.
// Settings are written through the APB port while no request is in flight.
// A request passes through a 24-stage pipeline (request decode, eight divider stages,
// eleven CORDIC stages, four multiply stages) and then the output serializer.
// Throughput: req takes one request per cycle while the pipeline has room;
// sustained, one flagged cell per cycle while rsp does not stall; a vertex or a
// quad holds the one-word result channel for each of its eight or six words.
// When rsp stalls with the last stage full, the pipeline holds; nothing is dropped
// or repeated, and a new run loads as the final word of the previous one is taken.
// Reset restores the default settings and empties the pipeline; no clearing pass.
`timescale 1ns / 1ps
module torus_mesh_generator (
	input  logic                      clk,
	input  logic                      arst_n,
	tmg_req_if.sink                   req,
	tmg_rsp_if.source                 rsp,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [tmg_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import tmg_pkg::*;

	localparam int DIV_OUT = 1 + DIV_STAGES;

	typedef struct packed {
		logic        func;
		logic        bad;
		logic [8:0]  tu;
		logic [7:0]  ra;
		logic [16:0] u;
		logic [15:0] v;
	} tag_t;

	cfg_t cfg;
	logic adv;
	logic ser_ready;
	logic load;
	logic vld_s [1:PIPE_DEPTH];
	tag_t tag_s [1:PIPE_DEPTH];
	tag_t tag_div;

	tmg_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	assign adv = !vld_s[PIPE_DEPTH] || ser_ready;
	assign load = adv && vld_s[PIPE_DEPTH];
	assign req.ready = adv;

	// request decode
	logic [9:0]  cols;
	logic        bad_cell;
	logic [25:0] prod;
	logic [40:0] na;
	tag_t        tag_in;
	div_t        din_c [LANES];
	div_t        din_s1 [LANES];
	logic [8:0]  dvs [LANES];
	logic [31:0] quo [LANES];

	always_comb begin
		cols = {1'b0, cfg.tube_segments} + (cfg.closed ? 10'd0 : 10'd1);
		if (req.func == FUNC_VERTEX)
			bad_cell = {1'b0, req.tube_index} >= cols
				|| {1'b0, req.ring_index} >= cfg.ring_segments;
		else
			bad_cell = req.tube_index >= cfg.tube_segments
				|| {1'b0, req.ring_index} >= cfg.ring_segments;
		tag_in.func = req.func;
		tag_in.bad = !cfg.ok || bad_cell;
		tag_in.tu = req.tube_index;
		tag_in.ra = req.ring_index;
		tag_in.u = '0;
		tag_in.v = '0;
		prod = 26'(req.tube_index) * 26'(cfg.sweep_turns);
		na = {prod[24:0], 16'h0} + 41'(cfg.tube_segments[8:1]);
		din_c[LANE_A].rem = na[40:32];
		din_c[LANE_A].w = na[31:0];
		din_c[LANE_B].rem = {1'b0, req.ring_index};
		din_c[LANE_B].w = 32'(cfg.ring_segments[8:1]);
		din_c[LANE_U].rem = '0;
		din_c[LANE_U].w = (32'(req.tube_index) << FRACTION_BITS)
			+ 32'(cfg.tube_segments[8:1]);
		din_c[LANE_V].rem = '0;
		din_c[LANE_V].w = (32'(req.ring_index) << FRACTION_BITS)
			+ 32'(cfg.ring_segments[8:1]);
		dvs[LANE_A] = cfg.tube_segments;
		dvs[LANE_B] = cfg.ring_segments;
		dvs[LANE_U] = cfg.tube_segments;
		dvs[LANE_V] = cfg.ring_segments;
	end

	// attach the texture coordinates as the tag leaves the divider
	always_comb begin
		tag_div = tag_s[DIV_OUT];
		tag_div.u = quo[LANE_U][16:0];
		tag_div.v = quo[LANE_V][15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= PIPE_DEPTH; i++)
				vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= req.valid;
			for (int i = 2; i <= PIPE_DEPTH; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s[1] <= tag_in;
			din_s1 <= din_c;
			for (int i = 2; i <= PIPE_DEPTH; i++) begin
				if (i == DIV_OUT + 1)
					tag_s[i] <= tag_div;
				else
					tag_s[i] <= tag_s[i-1];
			end
		end
	end

	tmg_divider u_div (.clk(clk), .en(adv), .din(din_s1), .dvs(dvs), .quo(quo));

	logic [31:0]        phase [2];
	logic signed [33:0] cos_val [2];
	logic signed [33:0] sin_val [2];

	assign phase[CS_A] = quo[LANE_A];
	assign phase[CS_B] = quo[LANE_B];

	tmg_cordic u_cordic (
		.clk(clk), .en(adv), .phase(phase), .cos_val(cos_val), .sin_val(sin_val)
	);

	// multiply stages
	logic signed [31:0] r_sgn;
	logic signed [65:0] p_rc_s21, p_w1_s21;
	logic signed [67:0] p_nx_s21, p_nz_s21;
	logic signed [33:0] ca_s21, sa_s21, sb_s21;
	logic signed [33:0] rc;
	logic signed [33:0] lever_s22, ca_s22, sa_s22;
	logic signed [31:0] w1_s22, w3_s22, w4_s22, w5_s22;
	logic signed [67:0] p_w0_s23, p_w2_s23;
	logic signed [31:0] w1_s23, w3_s23, w4_s23, w5_s23;
	logic [7:0][31:0]   res_s24;
	logic [7:0][31:0]   res_c;
	tag_t               tq;
	logic [9:0]         tu1;
	logic [8:0]         ra1;
	logic [17:0]        qa, qb, qc, qd;

	assign r_sgn = $signed({1'b0, cfg.minor_radius});
	assign rc = 34'((p_rc_s21 + (66'sd1 <<< 29)) >>> 30);

	always_ff @(posedge clk) begin
		if (adv) begin
			p_rc_s21 <= r_sgn * cos_val[CS_B];
			p_w1_s21 <= r_sgn * sin_val[CS_B];
			p_nx_s21 <= cos_val[CS_B] * cos_val[CS_A];
			p_nz_s21 <= cos_val[CS_B] * sin_val[CS_A];
			ca_s21 <= cos_val[CS_A];
			sa_s21 <= sin_val[CS_A];
			sb_s21 <= sin_val[CS_B];

			lever_s22 <= $signed({3'b000, cfg.major_radius}) + rc;
			ca_s22 <= ca_s21;
			sa_s22 <= sa_s21;
			w1_s22 <= round_sat(68'(p_w1_s21), 30);
			w3_s22 <= round_sat(p_nx_s21, 60 - FRACTION_BITS);
			w4_s22 <= round_sat(68'(sb_s21), 30 - FRACTION_BITS);
			w5_s22 <= round_sat(p_nz_s21, 60 - FRACTION_BITS);

			p_w0_s23 <= lever_s22 * ca_s22;
			p_w2_s23 <= lever_s22 * sa_s22;
			w1_s23 <= w1_s22;
			w3_s23 <= w3_s22;
			w4_s23 <= w4_s22;
			w5_s23 <= w5_s22;

			res_s24 <= res_c;
		end
	end

	// final words: vertex components or the quad's corner indices
	always_comb begin
		tq = tag_s[PIPE_DEPTH-1];
		tu1 = {1'b0, tq.tu} + 10'd1;
		if (cfg.closed && tu1 >= {1'b0, cfg.tube_segments})
			tu1 = '0;
		ra1 = {1'b0, tq.ra} + 9'd1;
		if (ra1 >= cfg.ring_segments)
			ra1 = '0;
		qa = 18'(tq.tu) * 18'(cfg.ring_segments) + 18'(tq.ra);
		qb = 18'(tu1) * 18'(cfg.ring_segments) + 18'(tq.ra);
		qc = 18'(tu1) * 18'(cfg.ring_segments) + 18'(ra1);
		qd = 18'(tq.tu) * 18'(cfg.ring_segments) + 18'(ra1);
		if (tq.func == FUNC_QUAD) begin
			res_c[0] = 32'(qa);
			res_c[1] = 32'(qd);
			res_c[2] = 32'(qb);
			res_c[3] = 32'(qb);
			res_c[4] = 32'(qd);
			res_c[5] = 32'(qc);
			res_c[6] = '0;
			res_c[7] = '0;
		end else begin
			res_c[0] = round_sat(p_w0_s23, 30);
			res_c[1] = w1_s23;
			res_c[2] = round_sat(p_w2_s23, 30);
			res_c[3] = w3_s23;
			res_c[4] = w4_s23;
			res_c[5] = w5_s23;
			res_c[6] = 32'(tq.u);
			res_c[7] = 32'(tq.v);
		end
	end

	res_t ser_in;

	always_comb begin
		ser_in.words = res_s24;
		ser_in.func = tag_s[PIPE_DEPTH].func;
		ser_in.bad = tag_s[PIPE_DEPTH].bad;
	end

	tmg_serializer u_ser (
		.clk(clk), .arst_n(arst_n), .load(load), .res(ser_in), .ser_ready(ser_ready),
		.rsp(rsp)
	);

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench of the torus mesh generator: directed cases, then random cells.
// Depends on tmg_pkg, tmg_channels and the torus_mesh_generator RTL.
`timescale 1ns / 1ps
module testbench;
	import tmg_pkg::*;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
		logic        bad;
	} word_t;

	typedef struct {
		logic       func;
		logic [8:0] tube;
		logic [7:0] ring;
		logic       typed;		// row carries a typed-in result
		word_t      typed_word;	// single flagged word
	} stim_row_t;

	localparam longint ATAN_T [20] = '{
		536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087,
		667544, 333772, 166886, 83443, 41722,
		20861, 10430, 5215, 2608, 1304
	};
	localparam int IDLE_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	tmg_req_if req ();
	tmg_rsp_if rsp ();

	torus_mesh_generator dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// mirror of the settings
	longint unsigned m_major, m_minor, m_ring, m_tube, m_sweep;
	word_t expected_words[$];
	int errors;
	int idle_cycles;
	bit stim_done;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rshift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic [31:0] sat(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	task automatic sin_cos(input logic [31:0] phase, output longint c, output longint s);
		logic [1:0]  q;
		logic [31:0] d;
		longint x, y, z, xs, ys;
		q = 2'((phase + 32'h20000000) >> 30);
		d = phase - {q, 30'd0};
		z = longint'($signed(d));
		x = 652032874;
		y = 0;
		for (int i = 0; i < 20; i++) begin
			xs = fshift(x, i);
			ys = fshift(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= ATAN_T[i];
			end else begin
				x += ys; y -= xs; z += ATAN_T[i];
			end
		end
		case (q)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	task automatic push_flag();
		expected_words.push_back('{word: 32'd0, last: 1'b1, bad: 1'b1});
	endtask

	// expected words of one cell request under the mirrored settings
	task automatic predict_cell(input logic func, input logic [8:0] tube_i,
			input logic [7:0] ring_i);
		longint unsigned tu, ra, cols, tu1, ra1, qa, qb, qc, qd;
		logic [31:0] pa, pb;
		longint ca, sa, cb, sb, lever;
		logic [31:0] w [8];
		bit closed;
		tu = tube_i;
		ra = ring_i;
		closed = (m_sweep == FULL_TURN);
		if (m_major == 0 || m_minor == 0 || m_ring < 3 || m_ring > MAX_SEGMENTS ||
				m_tube < 3 || m_tube > MAX_SEGMENTS || m_sweep == 0 || m_sweep > FULL_TURN) begin
			push_flag();
			return;
		end
		if (func == FUNC_VERTEX) begin
			cols = m_tube + (closed ? 0 : 1);
			if (tu >= cols || ra >= m_ring) begin
				push_flag();
				return;
			end
			pa = 32'((((tu * m_sweep) << 16) + m_tube / 2) / m_tube);
			pb = 32'(((ra << 32) + m_ring / 2) / m_ring);
			sin_cos(pa, ca, sa);
			sin_cos(pb, cb, sb);
			lever = longint'(m_major) + rshift(longint'(m_minor) * cb, 30);
			w[0] = sat(rshift(lever * ca, 30));
			w[1] = sat(rshift(longint'(m_minor) * sb, 30));
			w[2] = sat(rshift(lever * sa, 30));
			w[3] = sat(rshift(cb * ca, 60 - FRACTION_BITS));
			w[4] = sat(rshift(sb, 30 - FRACTION_BITS));
			w[5] = sat(rshift(cb * sa, 60 - FRACTION_BITS));
			w[6] = sat(longint'(((tu << FRACTION_BITS) + m_tube / 2) / m_tube));
			w[7] = sat(longint'(((ra << FRACTION_BITS) + m_ring / 2) / m_ring));
			for (int k = 0; k < 8; k++)
				expected_words.push_back('{word: w[k], last: k == 7, bad: 1'b0});
		end else begin
			if (tu >= m_tube || ra >= m_ring) begin
				push_flag();
				return;
			end
			tu1 = tu + 1;
			if (closed && tu1 >= m_tube)
				tu1 = 0;
			ra1 = (ra + 1 >= m_ring) ? 0 : ra + 1;
			qa = tu * m_ring + ra;
			qb = tu1 * m_ring + ra;
			qc = tu1 * m_ring + ra1;
			qd = tu * m_ring + ra1;
			w[0] = 32'(qa); w[1] = 32'(qd); w[2] = 32'(qb);
			w[3] = 32'(qb); w[4] = 32'(qd); w[5] = 32'(qc);
			for (int k = 0; k < 6; k++)
				expected_words.push_back('{word: w[k], last: k == 5, bad: 1'b0});
		end
	endtask

	task automatic write_setting(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
		paddr = ADDR_W'(4 * int'(idx)); pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		case (idx)
			REG_MAJOR: m_major = value[30:0];
			REG_MINOR: m_minor = value[30:0];
			REG_RING:  m_ring = value[8:0];
			REG_TUBE:  m_tube = value[8:0];
			REG_SWEEP: m_sweep = value[16:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [31:0] maj, input logic [31:0] mnr,
			input logic [31:0] rs, input logic [31:0] ts, input logic [31:0] sw);
		write_setting(REG_MAJOR, maj);
		write_setting(REG_MINOR, mnr);
		write_setting(REG_RING, rs);
		write_setting(REG_TUBE, ts);
		write_setting(REG_SWEEP, sw);
	endtask

	// drop the request after the last accepted one
	task automatic idle_req();
		@(negedge clk);
		req.valid <= 1'b0;
	endtask

	// drain, then wait before touching settings
	task automatic wait_drained();
		idle_req();
		while (expected_words.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// returns at the accepting edge; valid stays up until the next request or idle_req
	task automatic send_cell(input logic func, input logic [8:0] tube_i,
			input logic [7:0] ring_i);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.func <= func;
		req.tube_index <= tube_i;
		req.ring_index <= ring_i;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic send_random_cell();
		logic       func;
		logic [8:0] tube_i;
		logic [7:0] ring_i;
		func = 1'($urandom);
		if ($urandom_range(0, 9) < 8) begin
			tube_i = 9'($urandom_range(0, int'(m_tube)));
			ring_i = 8'($urandom_range(0, int'(m_ring > 255 ? 255 : m_ring - 1)));
		end else begin
			tube_i = 9'($urandom);
			ring_i = 8'($urandom);
		end
		predict_cell(func, tube_i, ring_i);
		send_cell(func, tube_i, ring_i);
	endtask

	// result side: random stalls, compare against the oldest expectation
	initial begin
		word_t want;
		int stall;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
			if (stall != 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected word expected none actual %h last %b bad %b",
					$time, rsp.word, rsp.last, rsp.bad_index);
			end else begin
				want = expected_words.pop_front();
				if (rsp.word !== want.word || rsp.last !== want.last ||
						rsp.bad_index !== want.bad) begin
					errors++;
					$display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
						want.word, want.last, want.bad, rsp.word, rsp.last, rsp.bad_index);
				end
			end
		end
	end

	// watchdog on cycles with no accepted request or word
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT && !stim_done) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t rows [$];
		stim_row_t row;
		word_t flag_word;
		errors = 0;
		stim_done = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		req.valid = 1'b0; req.func = FUNC_VERTEX; req.tube_index = '0; req.ring_index = '0;
		m_major = RST_MAJOR; m_minor = RST_MINOR; m_ring = RST_RING;
		m_tube = RST_TUBE; m_sweep = RST_SWEEP;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		flag_word = '{word: 32'd0, last: 1'b1, bad: 1'b1};
		// reset settings: origin, interior cells, wrap corners, out-of-range cells
		rows.push_back('{FUNC_VERTEX, 9'd0, 8'd0, 1'b0, '0});
		rows.push_back('{FUNC_VERTEX, 9'd31, 8'd15, 1'b0, '0});
		rows.push_back('{FUNC_VERTEX, 9'd8, 8'd4, 1'b0, '0});
		rows.push_back('{FUNC_VERTEX, 9'd16, 8'd8, 1'b0, '0});
		rows.push_back('{FUNC_QUAD, 9'd0, 8'd0, 1'b0, '0});
		rows.push_back('{FUNC_QUAD, 9'd31, 8'd15, 1'b0, '0});
		rows.push_back('{FUNC_VERTEX, 9'd32, 8'd0, 1'b1, flag_word});
		rows.push_back('{FUNC_VERTEX, 9'd511, 8'd255, 1'b1, flag_word});
		rows.push_back('{FUNC_QUAD, 9'd0, 8'd16, 1'b1, flag_word});
		rows.push_back('{FUNC_QUAD, 9'd32, 8'd0, 1'b1, flag_word});
		foreach (rows[i]) begin
			row = rows[i];
			if (row.typed)
				expected_words.push_back(row.typed_word);
			else
				predict_cell(row.func, row.tube, row.ring);
			send_cell(row.func, row.tube, row.ring);
		end
		wait_drained();

		// open sweep: extra column, no quad wrap
		apply_settings(32'h7fffffff, 32'h7fffffff, 32'd3, 32'd3, 32'd16384);
		send_cell(FUNC_VERTEX, 9'd3, 8'd2);
		predict_cell(FUNC_VERTEX, 9'd3, 8'd2);
		wait_drained();
		for (int i = 0; i < 4; i++) begin
			predict_cell(1'(i), 9'(i), 8'(i % 3));
			send_cell(1'(i), 9'(i), 8'(i % 3));
		end
		wait_drained();

		// invalid settings flag every request
		apply_settings(32'd0, 32'd1, 32'd2, 32'd257, 32'd0);
		expected_words.push_back(flag_word);
		send_cell(FUNC_VERTEX, 9'd0, 8'd0);
		expected_words.push_back(flag_word);
		send_cell(FUNC_QUAD, 9'd0, 8'd0);
		wait_drained();
		apply_settings(32'd1, 32'd1, 32'd256, 32'd256, 32'd65537);
		expected_words.push_back(flag_word);
		send_cell(FUNC_QUAD, 9'd1, 8'd1);
		wait_drained();

		// random phases, each under its own settings
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: apply_settings(32'd65536, 32'd16384, 32'd16, 32'd32, 32'd65536);
				1: apply_settings(32'd1, 32'd1, 32'd256, 32'd256, 32'd1);
				2: apply_settings(32'h7fffffff, 32'h40000000, 32'd3, 32'd5, 32'd65535);
				default: apply_settings($urandom_range(1, 32'h7fffffff),
					$urandom_range(1, 32'h7fffffff), $urandom_range(3, 256),
					$urandom_range(3, 256), $urandom_range(1, 65536));
			endcase
			for (int i = 0; i < 26; i++) begin
				send_random_cell();
				// hold off until every word has come
				if (i == 15) begin
					idle_req();
					while (expected_words.size() != 0) @(posedge clk);
				end
			end
			wait_drained();
		end

		stim_done = 1'b1;
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/tmg_pkg.sv
hw/rtl/tmg_channels.sv
hw/rtl/tmg_cfg.sv
hw/rtl/tmg_divider.sv
hw/rtl/tmg_cordic.sv
hw/rtl/tmg_serializer.sv
hw/rtl/torus_mesh_generator.sv
sim/testbench.sv
